[hdl/chs_pkg.sv]
// Shared types, constants and micro-operation codes of the chained hash set.
package chs_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_BUCKETS = 256;
  localparam int NODE_W      = 10;
  localparam int LINK_W      = 11;
  localparam int BKT_W       = 8;
  localparam int LG_W        = 4;
  localparam int CNT_W       = 11;
  localparam int BCNT_W      = 9;
  localparam int KEY_W       = 32;
  localparam int POS_W       = 10;

  localparam logic [LG_W-1:0]   MAX_LG    = LG_W'(8);
  localparam logic [LINK_W-1:0] NIL       = LINK_W'(MAX_ENTRIES);
  localparam logic [KEY_W-1:0]  HASH_MULT = 32'd2654435766;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [KEY_W-1:0] key;
    logic [BKT_W-1:0]        bucket_index;
    logic [POS_W-1:0]        chain_position;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] found_key;
    logic [BCNT_W-1:0]       bucket_count;
    logic [CNT_W-1:0]        element_count;
  } res_t;

  typedef enum logic [4:0] {
    UOP_NONE, UOP_LATCH, UOP_CLEAR, UOP_MUL_KEY, UOP_BKT, UOP_RD_HEAD, UOP_HEAD_CAP,
    UOP_RD_NODE, UOP_STEP_SEARCH, UOP_STEP_READ, UOP_TAKE_KEY, UOP_UNLINK,
    UOP_FREE_NODE, UOP_RD_FREE, UOP_ALLOC_FREE, UOP_ALLOC_FRESH, UOP_LINK_NEW,
    UOP_GROW_INIT, UOP_RD_OHEAD, UOP_GHEAD_CAP, UOP_NEXT_B, UOP_GROW_END,
    UOP_MUL_RD, UOP_BKT_G, UOP_RD_NHEAD, UOP_RELINK
  } uop_t;

  typedef struct packed {
    uop_t       uop;
    logic       fin;
    logic [1:0] status;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       cur_nil;
    logic       key_match;
    logic       idx_eq;
    logic       bidx_ok;
    logic       pool_full;
    logic       free_avail;
    logic       grow_ok;
    logic       scan_last;
  } sts_t;

endpackage

[hdl/chs_ctrl.sv]
// Controller state machine sequencing the hash set micro-operations.
module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  chs_pkg::sts_t sts,
  output chs_pkg::ctl_t ctl
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'b1 << 0,
    S_DISP   = 19'b1 << 1,
    S_BKT    = 19'b1 << 2,
    S_HEAD   = 19'b1 << 3,
    S_HCAP   = 19'b1 << 4,
    S_WALK   = 19'b1 << 5,
    S_WAITR  = 19'b1 << 6,
    S_FREE   = 19'b1 << 7,
    S_ALLOCF = 19'b1 << 8,
    S_LINK   = 19'b1 << 9,
    S_GCHK   = 19'b1 << 10,
    S_GHEAD  = 19'b1 << 11,
    S_GHCAP  = 19'b1 << 12,
    S_GWALK  = 19'b1 << 13,
    S_GMUL   = 19'b1 << 14,
    S_GBKT   = 19'b1 << 15,
    S_GNH    = 19'b1 << 16,
    S_GLINK  = 19'b1 << 17,
    S_FIN    = 19'b1 << 18
  } state_t;

  state_t     state, state_next;
  logic [1:0] st, st_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= chs_pkg::ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    ctl.uop    = chs_pkg::UOP_NONE;
    ctl.fin    = 1'b0;
    ctl.status = st;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.uop    = chs_pkg::UOP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.cmd == chs_pkg::CMD_CLEAR) begin
          ctl.uop    = chs_pkg::UOP_CLEAR;
          st_next    = chs_pkg::ST_OK;
          state_next = S_FIN;
        end else if (sts.cmd == chs_pkg::CMD_READ) begin
          if (sts.bidx_ok) begin
            ctl.uop    = chs_pkg::UOP_RD_HEAD;
            state_next = S_HCAP;
          end else begin
            st_next    = chs_pkg::ST_MISS;
            state_next = S_FIN;
          end
        end else if (sts.cmd == chs_pkg::CMD_INSERT || sts.cmd == chs_pkg::CMD_REMOVE ||
                     sts.cmd == chs_pkg::CMD_LOOKUP) begin
          ctl.uop    = chs_pkg::UOP_MUL_KEY;
          state_next = S_BKT;
        end else begin
          st_next    = chs_pkg::ST_MISS;
          state_next = S_FIN;
        end
      end
      S_BKT: begin
        ctl.uop    = chs_pkg::UOP_BKT;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        ctl.uop    = chs_pkg::UOP_RD_HEAD;
        state_next = S_HCAP;
      end
      S_HCAP: begin
        ctl.uop    = chs_pkg::UOP_HEAD_CAP;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!sts.cur_nil) begin
          ctl.uop    = chs_pkg::UOP_RD_NODE;
          state_next = S_WAITR;
        end else if (sts.cmd != chs_pkg::CMD_INSERT) begin
          st_next    = chs_pkg::ST_MISS;
          state_next = S_FIN;
        end else if (sts.pool_full) begin
          st_next    = chs_pkg::ST_FULL;
          state_next = S_FIN;
        end else if (sts.free_avail) begin
          ctl.uop    = chs_pkg::UOP_RD_FREE;
          state_next = S_ALLOCF;
        end else begin
          ctl.uop    = chs_pkg::UOP_ALLOC_FRESH;
          state_next = S_LINK;
        end
      end
      S_WAITR: begin
        if (sts.cmd == chs_pkg::CMD_READ) begin
          if (sts.idx_eq) begin
            ctl.uop    = chs_pkg::UOP_TAKE_KEY;
            st_next    = chs_pkg::ST_OK;
            state_next = S_FIN;
          end else begin
            ctl.uop    = chs_pkg::UOP_STEP_READ;
            state_next = S_WALK;
          end
        end else if (!sts.key_match) begin
          ctl.uop    = chs_pkg::UOP_STEP_SEARCH;
          state_next = S_WALK;
        end else if (sts.cmd == chs_pkg::CMD_REMOVE) begin
          ctl.uop    = chs_pkg::UOP_UNLINK;
          state_next = S_FREE;
        end else begin
          st_next    = (sts.cmd == chs_pkg::CMD_INSERT) ? chs_pkg::ST_DUP : chs_pkg::ST_OK;
          state_next = S_FIN;
        end
      end
      S_FREE: begin
        ctl.uop    = chs_pkg::UOP_FREE_NODE;
        st_next    = chs_pkg::ST_OK;
        state_next = S_FIN;
      end
      S_ALLOCF: begin
        ctl.uop    = chs_pkg::UOP_ALLOC_FREE;
        state_next = S_LINK;
      end
      S_LINK: begin
        ctl.uop    = chs_pkg::UOP_LINK_NEW;
        state_next = S_GCHK;
      end
      S_GCHK: begin
        st_next = chs_pkg::ST_OK;
        if (sts.grow_ok) begin
          ctl.uop    = chs_pkg::UOP_GROW_INIT;
          state_next = S_GHEAD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_GHEAD: begin
        ctl.uop    = chs_pkg::UOP_RD_OHEAD;
        state_next = S_GHCAP;
      end
      S_GHCAP: begin
        ctl.uop    = chs_pkg::UOP_GHEAD_CAP;
        state_next = S_GWALK;
      end
      S_GWALK: begin
        if (!sts.cur_nil) begin
          ctl.uop    = chs_pkg::UOP_RD_NODE;
          state_next = S_GMUL;
        end else if (sts.scan_last) begin
          ctl.uop    = chs_pkg::UOP_GROW_END;
          state_next = S_FIN;
        end else begin
          ctl.uop    = chs_pkg::UOP_NEXT_B;
          state_next = S_GHEAD;
        end
      end
      S_GMUL: begin
        ctl.uop    = chs_pkg::UOP_MUL_RD;
        state_next = S_GBKT;
      end
      S_GBKT: begin
        ctl.uop    = chs_pkg::UOP_BKT_G;
        state_next = S_GNH;
      end
      S_GNH: begin
        ctl.uop    = chs_pkg::UOP_RD_NHEAD;
        state_next = S_GLINK;
      end
      S_GLINK: begin
        ctl.uop    = chs_pkg::UOP_RELINK;
        state_next = S_GWALK;
      end
      S_FIN: begin
        ctl.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/chs_dp.sv]
// Datapath: node and bucket-head memories, hash multiplier, counters and config registers.
module chs_dp (
  input  logic          clk,
  input  logic          rst,
  input  chs_pkg::req_t request,
  input  chs_pkg::ctl_t ctl,
  output chs_pkg::sts_t sts,
  output logic          done,
  output chs_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int HA_W = chs_pkg::BKT_W + 1;

  logic [chs_pkg::KEY_W-1:0]  key_mem  [chs_pkg::MAX_ENTRIES];
  logic [chs_pkg::LINK_W-1:0] link_mem [chs_pkg::MAX_ENTRIES];
  logic [chs_pkg::LINK_W-1:0] head_mem [2*chs_pkg::MAX_BUCKETS];
  // valid bits of the active bank only; the other bank is filled with NIL during rehash
  logic [chs_pkg::MAX_BUCKETS-1:0] hvalid;

  chs_pkg::req_t              rq;
  logic [chs_pkg::KEY_W-1:0]  prod, rd_key, found;
  logic [chs_pkg::LINK_W-1:0] rd_link, hd_rd, cur, prev, hd, fresh, free_head;
  logic [chs_pkg::LINK_W-1:0] headval;
  logic                       hv_rd, bank;
  logic [chs_pkg::BKT_W-1:0]  bucket, b;
  logic [chs_pkg::POS_W-1:0]  idx;
  logic [chs_pkg::NODE_W-1:0] node;
  logic [chs_pkg::CNT_W-1:0]  stored;
  logic [chs_pkg::LG_W-1:0]   lg, lg_g, init_lg, limit;

  logic                       key_we, link_we, node_re, link_re, head_we, head_re;
  logic [chs_pkg::NODE_W-1:0] key_wa, link_wa, node_ra, link_ra;
  logic [chs_pkg::KEY_W-1:0]  key_wd;
  logic [chs_pkg::LINK_W-1:0] link_wd, head_wd;
  logic [HA_W-1:0]            head_wa, head_ra;

  function automatic logic [chs_pkg::BKT_W-1:0] bucket_of(
      input logic [chs_pkg::KEY_W-1:0] frac, input logic [chs_pkg::LG_W-1:0] l);
    return frac[chs_pkg::KEY_W-1 -: chs_pkg::BKT_W] >> (chs_pkg::MAX_LG - l);
  endfunction

  assign headval = hv_rd ? hd_rd : chs_pkg::NIL;
  assign lg_g    = chs_pkg::LG_W'(lg + 1'b1);
  assign pready  = 1'b1;
  assign prdata  = paddr[2] ? {28'b0, limit} : {28'b0, init_lg};

  assign sts.cmd        = rq.command;
  assign sts.cur_nil    = (cur == chs_pkg::NIL);
  assign sts.key_match  = (rd_key == rq.key);
  assign sts.idx_eq     = (idx == rq.chain_position);
  assign sts.bidx_ok    = ({1'b0, rq.bucket_index} < (chs_pkg::BCNT_W'(1) << lg));
  assign sts.pool_full  = (stored == chs_pkg::CNT_W'(chs_pkg::MAX_ENTRIES));
  assign sts.free_avail = (free_head != chs_pkg::NIL);
  assign sts.grow_ok    = ((stored >> lg) >= {7'b0, limit}) && (lg < chs_pkg::MAX_LG);
  assign sts.scan_last  = (b == chs_pkg::BKT_W'((chs_pkg::BCNT_W'(1) << lg) - 1'b1));

  always_comb begin
    key_we  = 1'b0;
    key_wa  = node;
    key_wd  = rq.key;
    link_we = 1'b0;
    link_wa = node;
    link_wd = hd;
    node_re = 1'b0;
    node_ra = cur[chs_pkg::NODE_W-1:0];
    link_re = 1'b0;
    link_ra = cur[chs_pkg::NODE_W-1:0];
    head_we = 1'b0;
    head_wa = {bank, bucket};
    head_wd = rd_link;
    head_re = 1'b0;
    head_ra = {bank, bucket};
    unique case (ctl.uop)
      chs_pkg::UOP_RD_HEAD: begin
        head_re = 1'b1;
        head_ra = {bank, (rq.command == chs_pkg::CMD_READ) ? rq.bucket_index : bucket};
      end
      chs_pkg::UOP_RD_OHEAD: begin
        head_re = 1'b1;
        head_ra = {bank, b};
        // old bucket b splits into new buckets 2b and 2b+1
        head_we = 1'b1;
        head_wa = {~bank, b[chs_pkg::BKT_W-2:0], 1'b0};
        head_wd = chs_pkg::NIL;
      end
      chs_pkg::UOP_GHEAD_CAP: begin
        head_we = 1'b1;
        head_wa = {~bank, b[chs_pkg::BKT_W-2:0], 1'b1};
        head_wd = chs_pkg::NIL;
      end
      chs_pkg::UOP_RD_NHEAD: begin
        head_re = 1'b1;
        head_ra = {~bank, bucket};
      end
      chs_pkg::UOP_RD_NODE: begin
        node_re = 1'b1;
        link_re = 1'b1;
      end
      chs_pkg::UOP_RD_FREE: begin
        link_re = 1'b1;
        link_ra = free_head[chs_pkg::NODE_W-1:0];
      end
      chs_pkg::UOP_LINK_NEW: begin
        key_we  = 1'b1;
        link_we = 1'b1;
        head_we = 1'b1;
        head_wd = {1'b0, node};
      end
      chs_pkg::UOP_UNLINK: begin
        if (prev != chs_pkg::NIL) begin
          link_we = 1'b1;
          link_wa = prev[chs_pkg::NODE_W-1:0];
          link_wd = rd_link;
        end else begin
          head_we = 1'b1;
        end
      end
      chs_pkg::UOP_FREE_NODE: begin
        link_we = 1'b1;
        link_wa = cur[chs_pkg::NODE_W-1:0];
        link_wd = free_head;
      end
      chs_pkg::UOP_RELINK: begin
        link_we = 1'b1;
        link_wa = cur[chs_pkg::NODE_W-1:0];
        link_wd = headval;
        head_we = 1'b1;
        head_wa = {~bank, bucket};
        head_wd = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (node_re) rd_key <= key_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) rd_link <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) hd_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_lg   <= chs_pkg::LG_W'(2);
      limit     <= chs_pkg::LG_W'(4);
      lg        <= chs_pkg::LG_W'(2);
      bank      <= 1'b0;
      stored    <= '0;
      fresh     <= '0;
      free_head <= chs_pkg::NIL;
      hvalid    <= '0;
      hv_rd     <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= ctl.fin;
      if (psel && penable && pwrite) begin
        if (paddr[2]) limit <= pwdata[chs_pkg::LG_W-1:0];
        else          init_lg <= pwdata[chs_pkg::LG_W-1:0];
      end
      if (head_re) begin
        hv_rd <= (head_ra[HA_W-1] != bank) || hvalid[head_ra[chs_pkg::BKT_W-1:0]];
      end
      if (head_we && (head_wa[HA_W-1] == bank)) begin
        hvalid[head_wa[chs_pkg::BKT_W-1:0]] <= 1'b1;
      end
      unique case (ctl.uop)
        chs_pkg::UOP_CLEAR: begin
          lg        <= (init_lg > chs_pkg::MAX_LG) ? chs_pkg::MAX_LG : init_lg;
          stored    <= '0;
          fresh     <= '0;
          free_head <= chs_pkg::NIL;
          hvalid    <= '0;
        end
        chs_pkg::UOP_ALLOC_FRESH: fresh <= chs_pkg::LINK_W'(fresh + 1'b1);
        chs_pkg::UOP_ALLOC_FREE:  free_head <= rd_link;
        chs_pkg::UOP_LINK_NEW:    stored <= chs_pkg::CNT_W'(stored + 1'b1);
        chs_pkg::UOP_FREE_NODE: begin
          free_head <= cur;
          stored    <= chs_pkg::CNT_W'(stored - 1'b1);
        end
        chs_pkg::UOP_GROW_END: begin
          bank   <= ~bank;
          lg     <= lg_g;
          hvalid <= '1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      result.status        <= ctl.status;
      result.found_key     <= found;
      result.bucket_count  <= chs_pkg::BCNT_W'(1) << lg;
      result.element_count <= stored;
    end
    unique case (ctl.uop)
      chs_pkg::UOP_LATCH: begin
        rq    <= request;
        found <= '0;
      end
      chs_pkg::UOP_MUL_KEY: prod <= chs_pkg::KEY_W'(rq.key * chs_pkg::HASH_MULT);
      chs_pkg::UOP_MUL_RD:  prod <= chs_pkg::KEY_W'(rd_key * chs_pkg::HASH_MULT);
      chs_pkg::UOP_BKT:     bucket <= bucket_of(prod, lg);
      chs_pkg::UOP_BKT_G:   bucket <= bucket_of(prod, lg_g);
      chs_pkg::UOP_HEAD_CAP: begin
        cur  <= headval;
        hd   <= headval;
        prev <= chs_pkg::NIL;
        idx  <= '0;
      end
      chs_pkg::UOP_STEP_SEARCH: begin
        prev <= cur;
        cur  <= rd_link;
      end
      chs_pkg::UOP_STEP_READ: begin
        cur <= rd_link;
        idx <= chs_pkg::POS_W'(idx + 1'b1);
      end
      chs_pkg::UOP_TAKE_KEY:    found <= rd_key;
      chs_pkg::UOP_ALLOC_FRESH: node <= fresh[chs_pkg::NODE_W-1:0];
      chs_pkg::UOP_ALLOC_FREE:  node <= free_head[chs_pkg::NODE_W-1:0];
      chs_pkg::UOP_GROW_INIT:   b <= '0;
      chs_pkg::UOP_GHEAD_CAP:   cur <= headval;
      chs_pkg::UOP_NEXT_B:      b <= chs_pkg::BKT_W'(b + 1'b1);
      chs_pkg::UOP_RELINK:      cur <= rd_link;
      default: ;
    endcase
  end

endmodule

[hdl/chained_hash_set_with_rehash_core.sv]
// Top level of the chained hash set with rehash.
// Usage: drive request and pulse start while busy is low; the request is
// taken at that edge and busy stays high until the command is finished.
// Exactly one result follows each request: done is high for one cycle
// with result valid; the receiver cannot stall, so it must take it then.
// Lookup, remove and insert walk the key's chain node by node; read-entry
// steps along the chain of the given bucket to the given position.
// An insert that doubles the bucket count adds a rehash pass over all old
// buckets, moving each stored key by its node read, hash multiply, bucket
// pick, head read and relink.
// A new request is taken as early as the done cycle.
// Configuration (initial_buckets_log2 at 0x0, load_limit at 0x4) goes over
// the APB port while idle; initial size applies at clear.
// Reset (synchronous, rst high) empties the table, restores both config
// registers and sets the size to 4 buckets; no clearing pass is needed.
module chained_hash_set_with_rehash_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  chs_pkg::req_t request,
  output logic          done,
  output chs_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  chs_pkg::ctl_t ctl;
  chs_pkg::sts_t sts;

  chs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  chs_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .sts     (sts),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

endmodule

[hdl/chs_check.sv]
// Port-level assertions for the hash set core, bound to the top level.
module chs_check (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input chs_pkg::req_t request,
  input logic          done,
  input chs_pkg::res_t result,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [2:0]    paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but busy not raised");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_bucket_pow2: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot(result.bucket_count)) else $error("bucket count not a power of two");

  a_key_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.status != chs_pkg::ST_OK |-> result.found_key == 0)
    else $error("found_key set on a failed request");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done) else $error("not idle after reset");

endmodule

bind chained_hash_set_with_rehash_core chs_check u_chk (.*);
